@@ rtl/ebwd_pkg.sv @@
// Package for the byte-to-word decoder: item types, command types, code constants
// and the small code helpers used by the front and back parts.
// Depends on nothing.
`timescale 1ns / 1ps

package ebwd_pkg;

  localparam int unsigned WordW   = 36;
  localparam int unsigned HalfW   = 18;
  localparam int unsigned CodeW   = 7;
  localparam int unsigned Slots   = 5;
  localparam int unsigned BinData = 4;

  // Byte values with a meaning of their own
  localparam logic [7:0] BYTE_MARKER_BASE = 8'o360;
  localparam logic [7:0] BYTE_TEXT_TOP    = 8'o200;
  localparam logic [7:0] BYTE_LF          = 8'o012;
  localparam logic [7:0] BYTE_CR          = 8'o015;
  localparam logic [7:0] BYTE_RUB         = 8'o177;
  localparam logic [7:0] BYTE_CR_ALONE    = 8'o356;
  localparam logic [7:0] BYTE_RUB_ALONE   = 8'o357;

  // 7-bit codes
  localparam logic [CodeW-1:0] CODE_LF   = 7'o012;
  localparam logic [CodeW-1:0] CODE_CR   = 7'o015;
  localparam logic [CodeW-1:0] CODE_RUB  = 7'o177;
  localparam logic [CodeW-1:0] CODE_BELL = 7'o007;
  localparam logic [CodeW-1:0] CODE_PAD  = 7'o003;

  localparam logic [3:0] MARKER_NIBBLE_MASK = 4'o17;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_MARKER = 2'd1,
    ST_TRUNC  = 2'd2
  } status_e;

  typedef struct packed {
    logic [HalfW-1:0] left_half;
    logic [HalfW-1:0] right_half;
    status_e          status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_TEXT,
    CMD_MARKER,
    CMD_RAW,
    CMD_END
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic             two_codes;
    logic [CodeW-1:0] code_a;
    logic [CodeW-1:0] code_b;
    logic [7:0]       raw;
  } cmd_t;

  function automatic logic [CodeW-1:0] swap_cr_lf(input logic [CodeW-1:0] c);
    logic [CodeW-1:0] r;
    r = c;
    if (c == CODE_LF) begin
      r = CODE_CR;
    end else if (c == CODE_CR) begin
      r = CODE_LF;
    end
    return r;
  endfunction

  // Places a code in its slot of a text word, most significant slot first.
  function automatic logic [WordW-1:0] place_code(input logic [CodeW-1:0] c,
                                                 input logic [2:0] slot);
    logic [WordW-1:0] r;
    case (slot)
      3'd0:    r = {c, 29'b0};
      3'd1:    r = {7'b0, c, 22'b0};
      3'd2:    r = {14'b0, c, 15'b0};
      3'd3:    r = {21'b0, c, 8'b0};
      3'd4:    r = {28'b0, c, 1'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

  // Pad code in every slot from the given one to the end of the word.
  function automatic logic [WordW-1:0] pad_fill(input logic [2:0] slot);
    logic [WordW-1:0] r;
    r = '0;
    for (int k = 0; k < Slots; k++) begin
      if (3'(k) >= slot) begin
        r = r | place_code(CODE_PAD, 3'(k));
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/ebwd_fifo.sv @@
// Small show-ahead queue built from registers, used between front and back parts
// and in front of the result ports. Depends on nothing.
`timescale 1ns / 1ps

module ebwd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

@@ rtl/ebwd_front.sv @@
// Front part of the decoder: classifies each accepted byte into a command and
// maps text bytes to their one or two 7-bit codes. Depends on ebwd_pkg.
`timescale 1ns / 1ps

module ebwd_front import ebwd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  logic     accept_i,
  output cmd_t     cmd_o
);

  // Bytes still owed to a binary word; they are taken raw, whatever their value.
  logic [2:0] bin_left_q, bin_left_d;
  logic [7:0] b;

  assign b = item_i.data_byte;

  always_comb begin
    cmd_o           = '0;
    cmd_o.raw       = b;
    cmd_o.kind      = CMD_TEXT;
    cmd_o.two_codes = 1'b0;
    cmd_o.code_a    = b[6:0];
    cmd_o.code_b    = CODE_BELL;
    bin_left_d      = bin_left_q;

    if (item_i.action) begin
      cmd_o.kind = CMD_END;
      bin_left_d = '0;
    end else if (bin_left_q != '0) begin
      cmd_o.kind = CMD_RAW;
      bin_left_d = bin_left_q - 1'b1;
    end else if (b >= BYTE_MARKER_BASE) begin
      cmd_o.kind = CMD_MARKER;
      bin_left_d = 3'(BinData);
    end else if (b < BYTE_TEXT_TOP) begin
      if (b == BYTE_LF) begin
        cmd_o.code_a    = CODE_CR;
        cmd_o.code_b    = CODE_LF;
        cmd_o.two_codes = 1'b1;
      end else if (b == BYTE_CR) begin
        cmd_o.code_a = CODE_LF;
      end else if (b == BYTE_RUB) begin
        cmd_o.code_a    = CODE_RUB;
        cmd_o.code_b    = CODE_BELL;
        cmd_o.two_codes = 1'b1;
      end
    end else if (b == BYTE_CR_ALONE) begin
      cmd_o.code_a = CODE_CR;
    end else if (b == BYTE_RUB_ALONE) begin
      cmd_o.code_a = CODE_RUB;
    end else begin
      // Escaped range: rubout prefix, then the low seven bits with CR and LF swapped
      // and a bell turned into a second rubout.
      cmd_o.code_a    = CODE_RUB;
      cmd_o.code_b    = (b[6:0] == CODE_BELL) ? CODE_RUB : swap_cr_lf(b[6:0]);
      cmd_o.two_codes = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_left_q <= '0;
    end else if (accept_i) begin
      bin_left_q <= bin_left_d;
    end
  end

endmodule

@@ rtl/ebwd_back.sv @@
// Back part of the decoder: assembles text and binary words from commands and
// produces one result at most per command. Depends on ebwd_pkg.
`timescale 1ns / 1ps

module ebwd_back import ebwd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  input  logic      res_full_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  logic [WordW-1:0] acc_q, acc_d;
  logic [2:0]       slot_q, slot_d;
  logic             bin_mode_q, bin_mode_d;
  logic [2:0]       bin_cnt_q, bin_cnt_d;

  logic [WordW-1:0] word;
  status_e          status;
  logic             emit;
  logic [WordW-1:0] acc1;
  logic [2:0]       slot1;

  assign cmd_pop_o = cmd_valid_i && !res_full_i;

  always_comb begin
    acc_d      = acc_q;
    slot_d     = slot_q;
    bin_mode_d = bin_mode_q;
    bin_cnt_d  = bin_cnt_q;
    word       = '0;
    status     = ST_OK;
    emit       = 1'b0;
    acc1       = acc_q | place_code(cmd_i.code_a, slot_q);
    slot1      = slot_q + 1'b1;

    case (cmd_i.kind)
      CMD_END: begin
        if (bin_mode_q) begin
          emit   = 1'b1;
          status = ST_TRUNC;
        end else if (slot_q != '0) begin
          emit = 1'b1;
          word = acc_q | pad_fill(slot_q);
        end
        acc_d      = '0;
        slot_d     = '0;
        bin_mode_d = 1'b0;
        bin_cnt_d  = '0;
      end
      CMD_MARKER: begin
        if (slot_q != '0) begin
          emit   = 1'b1;
          status = ST_MARKER;
        end
        acc_d      = {32'b0, cmd_i.raw[3:0] & MARKER_NIBBLE_MASK};
        slot_d     = '0;
        bin_mode_d = 1'b1;
        bin_cnt_d  = '0;
      end
      CMD_RAW: begin
        acc_d     = {acc_q[WordW-9:0], cmd_i.raw};
        bin_cnt_d = bin_cnt_q + 1'b1;
        if (bin_cnt_q == 3'(BinData - 1)) begin
          emit       = 1'b1;
          word       = acc_d;
          acc_d      = '0;
          bin_mode_d = 1'b0;
          bin_cnt_d  = '0;
        end
      end
      default: begin
        // Text: the first code may finish the word, and the second then opens the next.
        if (slot1 == 3'(Slots)) begin
          emit   = 1'b1;
          word   = acc1;
          acc_d  = cmd_i.two_codes ? place_code(cmd_i.code_b, '0) : '0;
          slot_d = cmd_i.two_codes ? 3'd1 : 3'd0;
        end else if (cmd_i.two_codes) begin
          acc_d  = acc1 | place_code(cmd_i.code_b, slot1);
          slot_d = slot1 + 1'b1;
          if (slot_d == 3'(Slots)) begin
            emit   = 1'b1;
            word   = acc_d;
            acc_d  = '0;
            slot_d = '0;
          end
        end else begin
          acc_d  = acc1;
          slot_d = slot1;
        end
      end
    endcase
  end

  assign res_valid_o      = cmd_pop_o && emit;
  assign res_o.left_half  = word[WordW-1:HalfW];
  assign res_o.right_half = word[HalfW-1:0];
  assign res_o.status     = status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= '0;
      slot_q     <= '0;
      bin_mode_q <= 1'b0;
      bin_cnt_q  <= '0;
    end else if (cmd_pop_o) begin
      acc_q      <= acc_d;
      slot_q     <= slot_d;
      bin_mode_q <= bin_mode_d;
      bin_cnt_q  <= bin_cnt_d;
    end
  end

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_q < 3'(Slots))
    else $error("text slot count out of range");

  a_mode_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_mode_q |-> (slot_q == '0))
    else $error("binary word assembled while text codes are held");

  a_bin_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !bin_mode_q |-> (bin_cnt_q == '0))
    else $error("binary byte count left over outside a binary word");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != ST_OK)) |->
      (res_o.left_half == '0 && res_o.right_half == '0))
    else $error("error result carries a non-zero word");

  a_text_low_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && cmd_i.kind == CMD_TEXT) |-> (res_o.right_half[0] == 1'b0))
    else $error("text word with low bit set");

endmodule

@@ rtl/evacuated_byte_to_word_decoder.sv @@
// Top level of the byte-to-word decoder: front classifier, command queue, back
// assembler and result queue. Depends on ebwd_pkg, ebwd_front, ebwd_back, ebwd_fifo.
`timescale 1ns / 1ps

// Decodes a stream of 8-bit bytes into 36-bit words given as two 18-bit halves.
// One byte is taken every clock cycle while full is low; the back assembler handles
// one command per cycle while the result queue is not full, and sets that rate. Each
// accepted byte's command is registered in the command queue, each finished word in
// the result queue. A request with action high ends the stream: a partial text word is
// padded and delivered, a partial binary word is reported as truncated, and the front
// and back return to reset state. The command queue lets the front keep taking bytes
// while the result side stalls; the result queue keeps finished words until popped.

module evacuated_byte_to_word_decoder import ebwd_pkg::*; #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  localparam int unsigned CmdW = $bits(cmd_t);
  localparam int unsigned ResW = $bits(out_item_t);

  cmd_t            front_cmd;
  logic [CmdW-1:0] cmd_bits;
  cmd_t            back_cmd;
  logic            cmd_empty;
  logic            cmd_pop;
  logic            res_full;
  logic            res_valid;
  out_item_t       res;
  logic [ResW-1:0] res_bits;
  logic            accept;

  assign accept     = push && !full;
  assign back_cmd   = cmd_t'(cmd_bits);
  assign out_item_o = out_item_t'(res_bits);

  ebwd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_item_i),
    .accept_i (accept),
    .cmd_o    (front_cmd)
  );

  ebwd_fifo #(
    .WIDTH (CmdW),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (CmdW'(front_cmd)),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_bits),
    .empty_o (cmd_empty)
  );

  ebwd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_valid_i (!cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ebwd_fifo #(
    .WIDTH (ResW),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (ResW'(res)),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_bits),
    .empty_o (empty)
  );

endmodule
